### src/skt_pkg.sv
// skt_pkg: shared types, codes and default sizes for the sorted key table
// no dependencies; used by skt_mem, skt_seq, sorted_key_table and tb
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  // default sizes, handed down from the top level
  localparam int DEPTH_DEF     = 256;
  localparam int KEY_WIDTH_DEF = 32;

  // fixed field widths of the words on the ports
  localparam int CMD_W      = 2;
  localparam int IN_KEY_W   = 32;
  localparam int OUT_NUM_W  = 9;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_DUP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED     = 2'd1;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [IN_KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [OUT_NUM_W-1:0] position;
    logic [STATUS_W-1:0]  status;
    logic [OUT_NUM_W-1:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic reject_duplicates;
    logic signed_keys;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_DECIDE,
    S_SHIFT_UP,
    S_WRITE_KEY,
    S_SHIFT_DN,
    S_DONE
  } seq_state_t;

endpackage

`default_nettype wire

### src/sorted_key_table.sv
// Sorted key table: keeps up to DEPTH keys in ascending order in one on-chip
// memory with a registered read. Each input word (insert, remove or find) runs a
// binary search at one probe per cycle, then inserts or removes by moving one
// entry per cycle through the memory's single read and write ports. A search
// makes at most ceil(log2(count+1)) probes; an insert then shifts each entry
// at or above its position up one slot, and a remove shifts each entry above
// its position down one slot. One word is worked on at a time; a finished
// result waits in an output register, so the next word is taken while it is
// unread. No clearing pass follows reset.
// Configuration writes are taken at any time and must be made while idle.
// depends on skt_pkg and skt_seq
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table #(
  parameter int DEPTH     = skt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire skt_pkg::in_word_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output skt_pkg::out_word_t                out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [skt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                         cfg_data
);

  import skt_pkg::*;

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_word_t out_data_r;
  logic      res_valid;
  logic      res_ready;
  out_word_t res_data;

  skt_seq #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reject_duplicates <= 1'b1;
      cfg_r.signed_keys       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REJECT_DUP: cfg_r.reject_duplicates <= cfg_data;
        CFG_SIGNED:     cfg_r.signed_keys       <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register, loads when empty or being read
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // a taken word keeps the sequencer busy on the next cycle
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer ready right after accepting a word");

  // a stalled result holds inside the sequencer
  a_result_holds : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while output register was full");

  // a full-table refusal reports a full count
  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res_data.status == STAT_FULL)
      |-> (res_data.entry_count == OUT_NUM_W'(DEPTH)))
    else $error("table full reported with count below depth");
`endif

endmodule

`default_nettype wire

### src/skt_mem.sv
// skt_mem: key store, one write port and one registered read port
// depends on skt_pkg for default sizes; used by skt_seq
`timescale 1ns / 1ps
`default_nettype none

module skt_mem #(
  parameter int DEPTH     = skt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic      [KEY_WIDTH-1:0]         rd_data,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [KEY_WIDTH-1:0]         wr_data
);

  logic [KEY_WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

### src/skt_seq.sv
// skt_seq: search and shift sequencer around the key store
// depends on skt_pkg and skt_mem; instantiated by sorted_key_table
`timescale 1ns / 1ps
`default_nettype none

module skt_seq #(
  parameter int DEPTH     = skt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = skt_pkg::KEY_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire skt_pkg::in_word_t in_data,
  input  wire skt_pkg::cfg_t     cfg,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output skt_pkg::out_word_t     res_data
);

  import skt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  seq_state_t state_r, state_nxt;

  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]       lb_r, lb_nxt;
  logic [CW-1:0]       ubp_r, ubp_nxt;   // upper bound plus one
  logic [CW-1:0]       pos_r, pos_nxt;
  logic                hit_r, hit_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       rd_addr_r;

  logic [AW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;

  logic [KEY_WIDTH-1:0] sign_mask;
  logic                 key_lt;
  logic                 key_eq;
  logic [CW-1:0]        mid_cw;
  logic [CW-1:0]        mid_inc;
  logic                 probe_done;
  logic [CW:0]          mid_sum;
  logic [AW-1:0]        probe_mid;
  logic                 is_insert;
  logic                 is_remove;
  logic                 ins_ok;
  logic                 need_up;
  logic                 rem_ok;
  logic                 need_dn;
  logic                 up_last;
  logic                 dn_last;

  skt_mem #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // key compare: stored entry against search key, sign bit flipped for signed mode
  assign sign_mask = KEY_WIDTH'(cfg.signed_keys) << (KEY_WIDTH - 1);
  assign key_lt    = (rd_data ^ sign_mask) < (key_r ^ sign_mask);
  assign key_eq    = (rd_data == key_r);

  // probe bookkeeping, the last read address is the midpoint
  assign mid_cw     = CW'(rd_addr_r);
  assign mid_inc    = mid_cw + CW'(1);
  assign probe_done = key_eq || (key_lt ? (mid_inc >= ubp_r) : (lb_r >= mid_cw));

  // next midpoint from the next bounds
  assign mid_sum   = {1'b0, lb_nxt} + {1'b0, ubp_nxt} - (CW + 1)'(1);
  assign probe_mid = mid_sum[AW:1];

  // command decisions once the search is over
  assign is_insert = (cmd_r == CMD_INSERT);
  assign is_remove = (cmd_r == CMD_REMOVE);
  assign ins_ok    = is_insert && !(hit_r && cfg.reject_duplicates)
                     && (count_r != CW'(DEPTH));
  assign need_up   = ins_ok && (count_r > pos_r);
  assign rem_ok    = is_remove && hit_r;
  assign need_dn   = rem_ok && ((pos_r + CW'(1)) < count_r);
  assign up_last   = (rd_addr_r == AW'(pos_r));
  assign dn_last   = (mid_cw == (count_r - CW'(1)));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (count_r == '0) ? S_DECIDE : S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (need_up) begin
          state_nxt = S_SHIFT_UP;
        end else if (ins_ok) begin
          state_nxt = S_WRITE_KEY;
        end else if (need_dn) begin
          state_nxt = S_SHIFT_DN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_UP: begin
        if (up_last) begin
          state_nxt = S_WRITE_KEY;
        end
      end
      S_WRITE_KEY: state_nxt = S_DONE;
      S_SHIFT_DN: begin
        if (dn_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready             = (state_r == S_IDLE);
    res_valid            = (state_r == S_DONE);
    res_data.position    = OUT_NUM_W'(pos_r);
    res_data.status      = status_r;
    res_data.entry_count = OUT_NUM_W'(count_r);
  end

  // datapath and memory port control
  always_comb begin
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    lb_nxt     = lb_r;
    ubp_nxt    = ubp_r;
    pos_nxt    = pos_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    rd_addr    = probe_mid;
    wr_en      = 1'b0;
    wr_addr    = rd_addr_r;
    wr_data    = rd_data;
    case (state_r)
      S_IDLE: begin
        // first probe is issued speculatively from the current count
        lb_nxt  = '0;
        ubp_nxt = count_r;
        pos_nxt = '0;
        hit_nxt = 1'b0;
        if (in_valid) begin
          cmd_nxt = in_data.command;
          key_nxt = KEY_WIDTH'(in_data.key);
        end
      end
      S_PROBE: begin
        if (key_eq) begin
          hit_nxt = 1'b1;
          pos_nxt = mid_cw;
        end else if (key_lt) begin
          lb_nxt  = mid_inc;
          pos_nxt = mid_inc;
        end else begin
          ubp_nxt = mid_cw;
          pos_nxt = mid_cw;
        end
      end
      S_DECIDE: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (hit_r && cfg.reject_duplicates) begin
              status_nxt = STAT_DUPLICATE;
            end else if (count_r == CW'(DEPTH)) begin
              status_nxt = STAT_FULL;
            end else begin
              status_nxt = STAT_OK;
            end
          end
          CMD_REMOVE: begin
            status_nxt = hit_r ? STAT_OK : STAT_NOT_FOUND;
            if (rem_ok && !need_dn) begin
              count_nxt = count_r - CW'(1);
            end
          end
          default: status_nxt = hit_r ? STAT_OK : STAT_NOT_FOUND;
        endcase
        if (need_up) begin
          rd_addr = AW'(count_r - CW'(1));
        end else if (need_dn) begin
          rd_addr = AW'(pos_r + CW'(1));
        end
      end
      S_SHIFT_UP: begin
        // move entry up one slot, walking downward toward the insert point
        wr_en   = 1'b1;
        wr_addr = rd_addr_r + AW'(1);
        rd_addr = rd_addr_r - AW'(1);
      end
      S_WRITE_KEY: begin
        wr_en     = 1'b1;
        wr_addr   = AW'(pos_r);
        wr_data   = key_r;
        count_nxt = count_r + CW'(1);
      end
      S_SHIFT_DN: begin
        // move entry down one slot, walking upward to the end of the table
        wr_en   = 1'b1;
        wr_addr = rd_addr_r - AW'(1);
        rd_addr = rd_addr_r + AW'(1);
        if (dn_last) begin
          count_nxt = count_r - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    lb_r      <= lb_nxt;
    ubp_r     <= ubp_nxt;
    pos_r     <= pos_nxt;
    hit_r     <= hit_nxt;
    status_r  <= status_nxt;
    rd_addr_r <= rd_addr;
  end

endmodule

`default_nettype wire

### test/tb.sv
// tb: self-checking bench for sorted_key_table, a directed table of words followed by
// random insert, remove and find traffic checked against a behavioral copy of the table
// depends on skt_pkg and sorted_key_table
`timescale 1ns / 1ps

module tb;
  import skt_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE_WAIT  = DEPTH + 16;   // worst insert shift plus search
  localparam int PRESSURE_AT  = 100;          // results seen before the long hold
  localparam int HOLD_CYCLES  = 400;

  // spare command code, decoded as a find
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_REJECT_DUP;
  logic                 cfg_data = 1'b0;

  sorted_key_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the table and its mode bits
  logic [IN_KEY_W-1:0] tbl_keys [DEPTH];
  int                  tbl_count = 0;
  logic                mode_reject = 1'b1;
  logic                mode_signed = 1'b0;

  out_word_t expected_q [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycles = 0;
  bit        steady = 1'b0;

  typedef struct packed {
    in_word_t  word;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // three-way key compare in the current mode
  function automatic int key_cmp(logic [IN_KEY_W-1:0] a, logic [IN_KEY_W-1:0] b);
    if (mode_signed) begin
      a[IN_KEY_W-1] = ~a[IN_KEY_W-1];
      b[IN_KEY_W-1] = ~b[IN_KEY_W-1];
    end
    if (a < b) return -1;
    if (a > b) return 1;
    return 0;
  endfunction

  // search, then apply the command to the shadow table; returns the result word
  function automatic out_word_t table_apply(in_word_t w);
    int        lb, ub, mid, c, pos, i;
    bit        hit, done;
    out_word_t r;
    lb = 0;
    ub = tbl_count - 1;
    pos = 0;
    hit = 1'b0;
    done = (tbl_count == 0);
    while (!done) begin
      mid = (lb + ub) / 2;
      c = key_cmp(tbl_keys[mid], w.key);
      if (c == 0) begin
        hit = 1'b1;
        pos = mid;
        done = 1'b1;
      end else if (c < 0) begin
        lb = mid + 1;
        if (lb > ub) begin
          pos = lb;
          done = 1'b1;
        end
      end else begin
        ub = mid - 1;
        if (lb > ub) begin
          pos = mid;
          done = 1'b1;
        end
      end
    end
    r.status = STAT_OK;
    if (w.command == CMD_INSERT) begin
      if (hit && mode_reject) begin
        r.status = STAT_DUPLICATE;
      end else if (tbl_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        for (i = tbl_count; i > pos; i--) tbl_keys[i] = tbl_keys[i-1];
        tbl_keys[pos] = w.key;
        tbl_count++;
      end
    end else if (w.command == CMD_REMOVE) begin
      if (hit) begin
        for (i = pos; i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i+1];
        tbl_count--;
      end else begin
        r.status = STAT_NOT_FOUND;
      end
    end else begin
      r.status = hit ? STAT_OK : STAT_NOT_FOUND;
    end
    r.position = pos[OUT_NUM_W-1:0];
    r.entry_count = tbl_count[OUT_NUM_W-1:0];
    return r;
  endfunction

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < 20);
  endfunction

  // keys: often ones already held, some extremes, some near zero or near all ones, the rest random
  function automatic logic [IN_KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 45 && tbl_count > 0) return tbl_keys[$urandom_range(tbl_count - 1)];
    if (r < 55) begin
      case ($urandom_range(3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    if (r < 65) return $urandom_range(1) ? $urandom_range(15) : (32'hFFFF_FFF0 | $urandom_range(15));
    return $urandom;
  endfunction

  function automatic in_word_t pick_word(int ins_pct, int rem_pct);
    in_word_t w;
    int       r;
    r = $urandom_range(99);
    if (r < ins_pct) w.command = CMD_INSERT;
    else if (r < ins_pct + rem_pct) w.command = CMD_REMOVE;
    else w.command = ($urandom_range(7) == 0) ? CMD_SPARE : CMD_FIND;
    w.key = pick_key();
    return w;
  endfunction

  function automatic void add_row(logic [CMD_W-1:0] cmd, logic [IN_KEY_W-1:0] key, bit typed,
                                  int pos, logic [STATUS_W-1:0] st, int cnt);
    dir_row_t d;
    d.word.command = cmd;
    d.word.key = key;
    d.typed = typed;
    d.res.position = pos[OUT_NUM_W-1:0];
    d.res.status = st;
    d.res.entry_count = cnt[OUT_NUM_W-1:0];
    dir_rows.push_back(d);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // offer one word; the expected result is booked when the word is taken
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t pred;
    while (idle_roll()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pred = table_apply(w);
    expected_q.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  task automatic send_random(input in_word_t w);
    send_word(w, 1'b0, '0);
  endtask

  // register write, only once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_REJECT_DUP) mode_reject = val;
    else if (idx == CFG_SIGNED) mode_signed = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // remove held keys until the table is empty, with some noise mixed in
  task automatic drain_table();
    in_word_t w;
    while (tbl_count != 0) begin
      if ($urandom_range(99) < 80) begin
        w.command = CMD_REMOVE;
        w.key = tbl_keys[$urandom_range(tbl_count - 1)];
      end else begin
        w = pick_word(10, 50);
      end
      send_random(w);
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: result expected none got %p", $time, out_data);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("position", want.position, out_data.position);
        check_field("status", want.status, out_data.status);
        check_field("entry_count", want.entry_count, out_data.entry_count);
      end
    end
  end

  // result sink: random stalls, one long hold to back the block up
  initial begin : result_sink
    int hold_left;
    bit pressed;
    hold_left = 0;
    pressed = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && results_seen >= PRESSURE_AT) begin
        pressed = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = !idle_roll();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int n;

    // directed words; typed results where the answer is obvious
    add_row(CMD_FIND,   32'h0000_0000, 1, 0, STAT_NOT_FOUND, 0);
    add_row(CMD_REMOVE, 32'h0000_0005, 1, 0, STAT_NOT_FOUND, 0);
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 1, 0, STAT_OK, 1);
    add_row(CMD_INSERT, 32'h0000_0000, 1, 0, STAT_OK, 2);
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 1, 1, STAT_DUPLICATE, 2);
    add_row(CMD_FIND,   32'h0000_0000, 1, 0, STAT_OK, 2);
    add_row(CMD_INSERT, 32'h8000_0000, 1, 1, STAT_OK, 3);
    add_row(CMD_FIND,   32'h7FFF_FFFF, 0, 0, STAT_OK, 0);
    add_row(CMD_SPARE,  32'h8000_0000, 1, 1, STAT_OK, 3);
    add_row(CMD_REMOVE, 32'h0000_0000, 1, 0, STAT_OK, 2);
    add_row(CMD_REMOVE, 32'h1234_5678, 0, 0, STAT_OK, 0);
    add_row(CMD_INSERT, 32'h0000_0001, 0, 0, STAT_OK, 0);
    add_row(CMD_INSERT, 32'h7FFF_FFFF, 0, 0, STAT_OK, 0);
    add_row(CMD_FIND,   32'h5555_5555, 0, 0, STAT_OK, 0);
    add_row(CMD_FIND,   32'hAAAA_AAAA, 0, 0, STAT_OK, 0);
    add_row(CMD_SPARE,  32'h0000_0000, 0, 0, STAT_OK, 0);
    add_row(CMD_REMOVE, 32'h8000_0000, 0, 0, STAT_OK, 0);
    add_row(CMD_REMOVE, 32'hFFFF_FFFF, 0, 0, STAT_OK, 0);
    add_row(CMD_REMOVE, 32'h0000_0001, 0, 0, STAT_OK, 0);
    add_row(CMD_REMOVE, 32'h7FFF_FFFF, 0, 0, STAT_OK, 0);
    add_row(CMD_FIND,   32'hFFFF_FFFF, 1, 0, STAT_NOT_FOUND, 0);

    // synchronous reset
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);

    // duplicates allowed, unsigned: fill to the top, bang on the full table, empty it
    write_reg(CFG_REJECT_DUP, 1'b0);
    while (tbl_count < DEPTH) send_random(pick_word(90, 0));
    for (n = 0; n < 24; n++) send_random(pick_word(60, 20));
    drain_table();

    // duplicates refused, signed; first stretch with no stalls on either side
    write_reg(CFG_REJECT_DUP, 1'b1);
    write_reg(CFG_SIGNED, 1'b1);
    steady = 1'b1;
    for (n = 0; n < 200; n++) begin
      if (n == 100) steady = 1'b0;
      send_random(pick_word(45, 25));
    end

    // duplicates allowed, signed; empty before the compare mode flips back
    write_reg(CFG_REJECT_DUP, 1'b0);
    for (n = 0; n < 120; n++) send_random(pick_word(45, 25));
    drain_table();

    // duplicates refused, unsigned
    write_reg(CFG_REJECT_DUP, 1'b1);
    write_reg(CFG_SIGNED, 1'b0);
    for (n = 0; n < 120; n++) send_random(pick_word(45, 25));

    // let everything come back, then a little longer for strays
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
